FILE: rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and helpers for the triangle rectangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int POS_W     = 24;
  localparam int TEX_W     = 16;
  localparam int COL_W     = 32;
  localparam int FLD_W     = POS_W + 1;
  localparam int T_W       = 17;
  localparam int FRAC_T    = 16;
  localparam int NFIELDS   = 8;
  localparam int MAXV      = 7;
  localparam int DATA_W    = 2 * POS_W + 2 * TEX_W + COL_W;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  localparam logic signed [POS_W-1:0] RST_LEFT   = 24'sd0;
  localparam logic signed [POS_W-1:0] RST_TOP    = 24'sd0;
  localparam logic signed [POS_W-1:0] RST_RIGHT  = 24'sd217088;
  localparam logic signed [POS_W-1:0] RST_BOTTOM = 24'sd131072;

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [TEX_W-1:0]        v;
    logic [TEX_W-1:0]        u;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } vtx_t;

  function automatic logic [COL_W-1:0] byte_rev(input logic [COL_W-1:0] c);
    byte_rev = {c[7:0], c[15:8], c[23:16], c[31:24]};
  endfunction

  function automatic logic signed [FLD_W-1:0] get_field(input vtx_t p,
                                                        input logic [2:0] k);
    logic signed [FLD_W-1:0] f;
    unique case (k)
      3'd0: f = FLD_W'(p.x);
      3'd1: f = FLD_W'(p.y);
      3'd2: f = $signed({9'd0, p.u});
      3'd3: f = $signed({9'd0, p.v});
      3'd4: f = $signed({17'd0, p.col[7:0]});
      3'd5: f = $signed({17'd0, p.col[15:8]});
      3'd6: f = $signed({17'd0, p.col[23:16]});
      default: f = $signed({17'd0, p.col[31:24]});
    endcase
    get_field = f;
  endfunction

  function automatic vtx_t set_field(input vtx_t p, input logic [2:0] k,
                                     input logic [FLD_W-1:0] val);
    vtx_t r;
    r = p;
    unique case (k)
      3'd0: r.x = val[POS_W-1:0];
      3'd1: r.y = val[POS_W-1:0];
      3'd2: r.u = val[TEX_W-1:0];
      3'd3: r.v = val[TEX_W-1:0];
      3'd4: r.col[7:0]   = val[7:0];
      3'd5: r.col[15:8]  = val[7:0];
      3'd6: r.col[23:16] = val[7:0];
      default: r.col[31:24] = val[7:0];
    endcase
    set_field = r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/triangle_rect_clip_fan.sv
// ----------------------------------------------------------------------------
// triangle_rect_clip_fan
// Clips each triangle of a vertex stream to a rectangle and fans it out.
// ----------------------------------------------------------------------------
// Vertices enter one per item; the first two of a triangle are stored and
// the third starts four clip passes (left, right, top, bottom) over a
// two-bank polygon buffer: each polygon edge is fetched, tested and stepped,
// and when the edge crosses the limit it also passes through the serial
// divider and the shared interpolating multiplier. The surviving polygon of
// n vertices leaves as (n-2)*3 items, each held until it is accepted. The
// block takes no vertex while a triangle is in flight. Clip registers are
// written on the cfg channel: 0 left, 1 top, 2 right, 3 bottom, Q15.8.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_rect_clip_fan (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, tex_u, tex_v, color_in
  input  wire logic [trc_pkg::DATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // out_x, out_y, out_u, out_v, out_color
  output logic      [trc_pkg::DATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [trc_pkg::POS_W-1:0]    cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_RDC  = 12'b000000000010,
    S_RDN  = 12'b000000000100,
    S_EVAL = 12'b000000001000,
    S_CHK  = 12'b000000010000,
    S_DIV  = 12'b000000100000,
    S_MIX  = 12'b000001000000,
    S_NEXT = 12'b000010000000,
    S_FAN  = 12'b000100000000,
    S_FRD  = 12'b001000000000,
    S_FLD  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state;

  logic signed [trc_pkg::POS_W-1:0] clip_left, clip_top, clip_right, clip_bottom;

  trc_pkg::vtx_t mem [16];
  trc_pkg::vtx_t rdata;
  logic [3:0]    raddr;

  logic [1:0] phase;
  logic [1:0] pass;
  logic       bank;
  logic [2:0] n, cnt, i, fi;
  logic [1:0] slot;
  trc_pkg::vtx_t cur, nxt, in_vtx, mix_r;

  logic signed [trc_pkg::FLD_W-1:0] cv, nv, lim, numd, dend;
  logic                             cin, nin;
  logic                             div_start, div_done, mix_start, mix_done;
  logic [trc_pkg::T_W-1:0]          t;
  logic [2:0]                       nexti;

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  assign in_vtx.x   = s_tdata[23:0];
  assign in_vtx.y   = s_tdata[47:24];
  assign in_vtx.u   = s_tdata[63:48];
  assign in_vtx.v   = s_tdata[79:64];
  assign in_vtx.col = trc_pkg::byte_rev(s_tdata[111:80]);

  always_comb begin
    cv  = pass[1] ? trc_pkg::FLD_W'(cur.y) : trc_pkg::FLD_W'(cur.x);
    nv  = pass[1] ? trc_pkg::FLD_W'(nxt.y) : trc_pkg::FLD_W'(nxt.x);
    unique case (pass)
      2'd0: lim = trc_pkg::FLD_W'(clip_left);
      2'd1: lim = trc_pkg::FLD_W'(clip_right);
      2'd2: lim = trc_pkg::FLD_W'(clip_top);
      default: lim = trc_pkg::FLD_W'(clip_bottom);
    endcase
    cin  = pass[0] ? (cv <= lim) : (cv >= lim);
    nin  = pass[0] ? (nv <= lim) : (nv >= lim);
    numd = lim - cv;
    dend = nv - cv;
    if (numd[trc_pkg::FLD_W-1]) numd = -numd;
    if (dend[trc_pkg::FLD_W-1]) dend = -dend;
    nexti = (i + 3'd1 == n) ? 3'd0 : i + 3'd1;
  end

  always_comb begin
    unique case (state)
      S_RDC:   raddr = {bank, i};
      S_RDN:   raddr = {bank, nexti};
      S_FRD: begin
        unique case (slot)
          2'd0:    raddr = {bank, 3'd0};
          2'd1:    raddr = {bank, fi};
          default: raddr = {bank, fi + 3'd1};
        endcase
      end
      default: raddr = {bank, i};
    endcase
  end

  assign div_start = state == S_CHK && cin != nin;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= trc_pkg::RST_LEFT;
      clip_top    <= trc_pkg::RST_TOP;
      clip_right  <= trc_pkg::RST_RIGHT;
      clip_bottom <= trc_pkg::RST_BOTTOM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        trc_pkg::REG_LEFT:   clip_left   <= cfg_data;
        trc_pkg::REG_TOP:    clip_top    <= cfg_data;
        trc_pkg::REG_RIGHT:  clip_right  <= cfg_data;
        trc_pkg::REG_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      pass      <= '0;
      bank      <= 1'b0;
      n         <= '0;
      cnt       <= '0;
      i         <= '0;
      fi        <= '0;
      slot      <= '0;
      m_tvalid  <= 1'b0;
      mix_start <= 1'b0;
    end else begin
      mix_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (phase == 2'd0 || phase == 2'd1) begin
              mem[{1'b0, 1'b0, phase}] <= in_vtx;
              phase <= phase + 2'd1;
            end else begin
              mem[{1'b0, 3'd2}] <= in_vtx;
              phase <= '0;
              pass  <= '0;
              bank  <= 1'b0;
              n     <= 3'd3;
              cnt   <= '0;
              i     <= '0;
              state <= S_RDC;
            end
          end
        end
        S_RDC:  state <= S_RDN;
        S_RDN: begin
          cur   <= rdata;
          state <= S_EVAL;
        end
        S_EVAL: begin
          nxt   <= rdata;
          state <= S_CHK;
        end
        S_CHK: begin
          if (cin && cnt < 3'(trc_pkg::MAXV)) begin
            mem[{~bank, cnt}] <= cur;
            cnt <= cnt + 3'd1;
          end
          state <= (cin != nin) ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          if (div_done) begin
            mix_start <= 1'b1;
            state     <= S_MIX;
          end
        end
        S_MIX: begin
          if (mix_done) begin
            if (cnt < 3'(trc_pkg::MAXV)) begin
              mem[{~bank, cnt}] <= mix_r;
              cnt <= cnt + 3'd1;
            end
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (i + 3'd1 == n) begin
            n    <= cnt;
            cnt  <= '0;
            i    <= '0;
            bank <= ~bank;
            pass <= pass + 2'd1;
            if (cnt == '0) state <= S_IDLE;
            else if (pass == 2'd3) state <= S_FAN;
            else state <= S_RDC;
          end else begin
            i     <= i + 3'd1;
            state <= S_RDC;
          end
        end
        S_FAN: begin
          fi   <= 3'd1;
          slot <= '0;
          state <= (n < 3'd3) ? S_IDLE : S_FRD;
        end
        S_FRD: state <= S_FLD;
        S_FLD: begin
          m_tdata  <= rdata;
          m_tlast  <= slot == 2'd2 && fi + 3'd2 == n;
          m_tvalid <= 1'b1;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (slot == 2'd2) begin
              slot <= '0;
              fi   <= fi + 3'd1;
              state <= (fi + 3'd2 == n) ? S_IDLE : S_FRD;
            end else begin
              slot  <= slot + 2'd1;
              state <= S_FRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  trc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (numd),
    .den   (dend),
    .t     (t),
    .done  (div_done)
  );

  trc_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .a     (cur),
    .b     (nxt),
    .t     (t),
    .r     (mix_r),
    .done  (mix_done)
  );

endmodule

`default_nettype wire

FILE: rtl/trc_div.sv
// ----------------------------------------------------------------------------
// trc_div
// Serial restoring divider for the crossing factor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [trc_pkg::FLD_W-1:0] num,
  input  wire logic [trc_pkg::FLD_W-1:0] den,
  output logic      [trc_pkg::T_W-1:0]   t,
  output logic                           done
);

  localparam logic [trc_pkg::T_W-1:0] T_W_ONE = 1 << trc_pkg::FRAC_T;

  logic                      busy;
  logic [4:0]                cnt;
  logic [trc_pkg::FLD_W-1:0] rem;
  logic [trc_pkg::FLD_W-1:0] dv;
  logic [trc_pkg::FLD_W:0]   rem2;
  logic                      ge;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dv  <= den;
        rem <= num;
        if (den == '0) begin
          t    <= '0;
          done <= 1'b1;
        end else if (num >= den) begin
          t    <= T_W_ONE;
          done <= 1'b1;
        end else begin
          t    <= '0;
          busy <= 1'b1;
          cnt  <= 5'(trc_pkg::FRAC_T);
        end
      end else if (busy) begin
        rem <= ge ? trc_pkg::FLD_W'(rem2 - {1'b0, dv}) : rem2[trc_pkg::FLD_W-1:0];
        t   <= {t[trc_pkg::T_W-2:0], ge};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/trc_lerp.sv
// ----------------------------------------------------------------------------
// trc_lerp
// Vertex interpolator: one shared multiplier walks the eight fields in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_lerp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire trc_pkg::vtx_t           a,
  input  wire trc_pkg::vtx_t           b,
  input  wire logic [trc_pkg::T_W-1:0] t,
  output trc_pkg::vtx_t                r,
  output logic                         done
);

  logic                             busy;
  logic                             ph;
  logic [2:0]                       k;
  logic signed [trc_pkg::FLD_W-1:0] fa;
  logic signed [trc_pkg::FLD_W-1:0] fb;
  logic signed [trc_pkg::FLD_W:0]   d;
  logic signed [trc_pkg::FLD_W+trc_pkg::T_W+1:0] prod;
  logic signed [trc_pkg::FLD_W+trc_pkg::T_W+1:0] q;
  logic [trc_pkg::FLD_W-1:0]        res;

  assign fa  = trc_pkg::get_field(a, k);
  assign fb  = trc_pkg::get_field(b, k);
  assign d   = (trc_pkg::FLD_W+1)'(fb) - (trc_pkg::FLD_W+1)'(fa);
  assign q   = prod >>> trc_pkg::FRAC_T;
  assign res = trc_pkg::FLD_W'(fa + q[trc_pkg::FLD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph   <= 1'b0;
        k    <= '0;
        r    <= a;
      end else if (busy) begin
        if (!ph) begin
          prod <= $signed({1'b0, t}) * d;
          ph   <= 1'b1;
        end else begin
          r  <= trc_pkg::set_field(r, k, res);
          ph <= 1'b0;
          k  <= k + 3'd1;
          if (k == 3'(trc_pkg::NFIELDS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
